>>> hw/rtl/ffpa_pkg.sv
package ffpa_pkg;

	// map geometry
	localparam int PAGES = 1024;
	localparam int WORD_W = 64;
	localparam int OFF_W = 6;
	localparam int WORDS = (PAGES + WORD_W - 1) / WORD_W;
	localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int SCAN_W = WIDX_W + 1;
	localparam int LEN_W = OFF_W + 1;

	// page arithmetic, wide enough for first page plus count
	localparam int SUM_W = 17;

	// item field widths
	localparam int COUNT_W = 11;
	localparam int FIRST_W = 16;
	localparam int PAGE_W = 10;
	localparam logic [FIRST_W-1:0] BAD_PAGE_ID = '1;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_ROOM = 2'd1,
		ST_RANGE   = 2'd2
	} status_t;

	typedef struct packed {
		logic               operation;
		logic [COUNT_W-1:0] count;
		logic [FIRST_W-1:0] first_page;
	} req_t;

	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic [1:0]        status;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_MARK,
		S_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    scan_init;
		logic    scan_step;
		logic    mark_init;
		logic    mark_step;
		logic    set_res;
		logic    res_start;
		status_t res_status;
		logic    emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic    trivial;
		status_t triv_status;
		logic    is_free;
		logic    found;
		logic    exhausted;
		logic    mark_last;
	} sts_t;

endpackage

>>> hw/rtl/ffpa_dpath.sv
module ffpa_dpath import ffpa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  cmd_t cmd,
	output sts_t sts,
	output rsp_t res
);

	localparam logic [WORD_W-1:0] ONES = '1;

	req_t               req_q;
	logic [WORD_W-1:0]  used_q [WORDS];

	logic [SCAN_W-1:0]  a_q;
	logic               v_s1;
	logic [LEN_W-1:0]   len_s1 [WORD_W];
	logic [WIDX_W-1:0]  base_s1;

	logic [SUM_W-1:0]   run_q;
	logic               found_q;
	logic               exhausted_q;
	logic [SUM_W-1:0]   end_q;

	logic [SUM_W-1:0]   lo_q;
	logic [SUM_W-1:0]   hi_q;
	logic [WIDX_W-1:0]  m_q;
	rsp_t               res_q;

	logic               is_free;
	logic [SUM_W-1:0]   cnt_w;
	logic [SUM_W-1:0]   first_w;
	logic [SUM_W-1:0]   free_end;
	logic               trivial;
	status_t            triv_status;

	logic [WORD_W-1:0]  word_a;
	logic [WORD_W-1:0]  free_a;
	logic [SUM_W-1:0]   base_page_a;
	logic [LEN_W-1:0]   lvl [OFF_W+1][WORD_W];

	logic [SUM_W-1:0]   run_b [WORD_W];
	logic [WORD_W-1:0]  hit_b;
	logic [OFF_W-1:0]   pos_b;
	logic               any_b;
	logic               full_b;

	logic [SUM_W-1:0]   lo_n;
	logic [SUM_W-1:0]   hi_n;
	logic [WIDX_W-1:0]  lo_w;
	logic [WIDX_W-1:0]  hi_w;
	logic [WORD_W-1:0]  mask_lo;
	logic [WORD_W-1:0]  mask_hi;
	logic [WORD_W-1:0]  mask;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	// decode of requests that need no map access
	assign is_free  = (req_q.operation == OP_FREE);
	assign cnt_w    = SUM_W'(req_q.count);
	assign first_w  = SUM_W'(req_q.first_page);
	assign free_end = first_w + cnt_w;

	always_comb begin
		trivial     = 1'b0;
		triv_status = ST_OK;
		if (is_free) begin
			if (req_q.first_page == BAD_PAGE_ID) begin
				trivial = 1'b1;
			end else if (free_end > SUM_W'(PAGES)) begin
				trivial     = 1'b1;
				triv_status = ST_RANGE;
			end else if (req_q.count == '0) begin
				trivial = 1'b1;
			end
		end else begin
			if (req_q.count == '0) begin
				trivial = 1'b1;
			end else if (cnt_w > SUM_W'(PAGES)) begin
				trivial     = 1'b1;
				triv_status = ST_NO_ROOM;
			end
		end
	end

	// scan stage 1: free-run length ending at each bit of one word, by doubling
	always_comb begin
		int step;
		int idx;
		step        = 0;
		idx         = 0;
		word_a      = used_q[a_q[WIDX_W-1:0]];
		base_page_a = SUM_W'(a_q) << OFF_W;
		for (int j = 0; j < WORD_W; j++) begin
			free_a[j]  = !word_a[j] && ((base_page_a + SUM_W'(j)) < SUM_W'(PAGES));
			lvl[0][j]  = LEN_W'(free_a[j]);
		end
		for (int k = 0; k < OFF_W; k++) begin
			step = 1 << k;
			for (int j = 0; j < WORD_W; j++) begin
				idx = (j >= step) ? (j - step) : j;
				if ((j >= step) && (lvl[k][j] == LEN_W'(step))) begin
					lvl[k+1][j] = lvl[k][j] + lvl[k][idx];
				end else begin
					lvl[k+1][j] = lvl[k][j];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q  <= '0;
			v_s1 <= 1'b0;
		end else if (cmd.scan_init) begin
			a_q  <= '0;
			v_s1 <= 1'b0;
		end else if (cmd.scan_step && (a_q < SCAN_W'(WORDS))) begin
			a_q  <= a_q + 1'b1;
			v_s1 <= 1'b1;
		end else begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			for (int j = 0; j < WORD_W; j++) begin
				len_s1[j] <= lvl[OFF_W][j];
			end
			base_s1 <= a_q[WIDX_W-1:0];
		end
	end

	// scan stage 2: join with the run carried in from lower words, first fit
	always_comb begin
		for (int j = 0; j < WORD_W; j++) begin
			if (len_s1[j] == LEN_W'(j + 1)) begin
				run_b[j] = run_q + SUM_W'(j + 1);
			end else begin
				run_b[j] = SUM_W'(len_s1[j]);
			end
			hit_b[j] = (run_b[j] >= cnt_w);
		end
		any_b = |hit_b;
		pos_b = '0;
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if (hit_b[j]) begin
				pos_b = OFF_W'(j);
			end
		end
	end

	assign full_b = (len_s1[WORD_W-1] == LEN_W'(WORD_W));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= '0;
			found_q     <= 1'b0;
			exhausted_q <= 1'b0;
			end_q       <= '0;
		end else if (cmd.scan_init) begin
			run_q       <= '0;
			found_q     <= 1'b0;
			exhausted_q <= 1'b0;
		end else if (v_s1 && !found_q && !exhausted_q) begin
			if (any_b) begin
				found_q <= 1'b1;
				end_q   <= (SUM_W'(base_s1) << OFF_W) | SUM_W'(pos_b);
			end else begin
				run_q <= full_b ? (run_q + SUM_W'(WORD_W)) : SUM_W'(len_s1[WORD_W-1]);
				if (base_s1 == WIDX_W'(WORDS - 1)) begin
					exhausted_q <= 1'b1;
				end
			end
		end
	end

	// run to mark or clear, inclusive page bounds
	always_comb begin
		if (is_free) begin
			lo_n = first_w;
			hi_n = free_end - 1'b1;
		end else begin
			lo_n = end_q - cnt_w + 1'b1;
			hi_n = end_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mark_init) begin
			lo_q <= lo_n;
			hi_q <= hi_n;
			m_q  <= WIDX_W'(lo_n >> OFF_W);
		end else if (cmd.mark_step) begin
			m_q  <= m_q + 1'b1;
		end
	end

	// word mask for the current word of the run
	assign lo_w    = WIDX_W'(lo_q >> OFF_W);
	assign hi_w    = WIDX_W'(hi_q >> OFF_W);
	assign mask_lo = (m_q == lo_w) ? (ONES << lo_q[OFF_W-1:0]) : ONES;
	assign mask_hi = (m_q == hi_w) ? (ONES >> (OFF_W'(WORD_W - 1) - hi_q[OFF_W-1:0])) : ONES;
	assign mask    = mask_lo & mask_hi;

	// used map, one word written per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < WORDS; w++) begin
				used_q[w] <= '0;
			end
		end else if (cmd.mark_step) begin
			if (is_free) begin
				used_q[m_q] <= used_q[m_q] & ~mask;
			end else begin
				used_q[m_q] <= used_q[m_q] | mask;
			end
		end
	end

	// result of the item
	always_ff @(posedge clk) begin
		if (cmd.set_res) begin
			res_q.page   <= cmd.res_start ? PAGE_W'(lo_q) : '0;
			res_q.status <= cmd.res_status;
		end
	end

	assign res = res_q;

	assign sts.trivial     = trivial;
	assign sts.triv_status = triv_status;
	assign sts.is_free     = is_free;
	assign sts.found       = found_q;
	assign sts.exhausted   = exhausted_q;
	assign sts.mark_last   = (m_q == hi_w);

endmodule

>>> hw/rtl/ffpa_ctrl.sv
module ffpa_ctrl import ffpa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic out_free,
	input  sts_t sts,
	output logic busy,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.trivial) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = sts.triv_status;
					state_d        = S_FINISH;
				end else if (sts.is_free) begin
					cmd.mark_init = 1'b1;
					state_d       = S_MARK;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.found) begin
					cmd.mark_init = 1'b1;
					state_d       = S_MARK;
				end else if (sts.exhausted) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_NO_ROOM;
					state_d        = S_FINISH;
				end
			end
			S_MARK: begin
				cmd.mark_step = 1'b1;
				if (sts.mark_last) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_OK;
					cmd.res_start  = !sts.is_free;
					state_d        = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/first_fit_page_run_allocator_core.sv
// channel   dir   handshake                payload
// req       in    req_valid / req_stall    req_t  (operation, count, first_page)
// rsp       out   rsp_valid / rsp_stall    rsp_t  (page, status)
//
// one item at a time: accept, check, then scan and/or mark, then hand over
// allocate scans one 64-page word a cycle through a two-stage pipe, then
// marks one word a cycle over the run (up to 16 words)
// free items skip the scan; trivial items skip both scan and mark
// reset clears the used map to all free at once; no clearing pass
// a result waiting on rsp_stall does not block acceptance of the next item
module first_fit_page_run_allocator_core import ffpa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	cmd_t cmd;
	sts_t sts;
	rsp_t res;
	logic busy;
	logic out_free;
	logic rsp_valid_q;
	rsp_t rsp_q;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = busy;

	ffpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.out_free  (out_free),
		.sts       (sts),
		.busy      (busy),
		.cmd       (cmd)
	);

	ffpa_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.res    (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> verif/tb.sv
module tb import ffpa_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1500;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 20000;
	localparam int SETTLE_CYCLES = 40;

	// page map mirror with in-order result checking
	class page_map_scoreboard;
		bit   used[PAGES];
		rsp_t pending_results[$];
		int   mismatches;
		int   n_placed, n_refused, n_zero_alloc;
		int   n_freed, n_out_of_range, n_invalid_id;
		int   n_checked;

		function new();
			foreach (used[i])
				used[i] = 1'b0;
			mismatches = 0;
			n_placed = 0;
			n_refused = 0;
			n_zero_alloc = 0;
			n_freed = 0;
			n_out_of_range = 0;
			n_invalid_id = 0;
			n_checked = 0;
		endfunction

		// update the mirrored map and work out the item's result
		function rsp_t apply_request(req_t r);
			rsp_t res;
			int   run;
			int   start;
			int   i;
			res.page = '0;
			res.status = ST_OK;
			if (r.operation == OP_ALLOC) begin
				if (r.count == 0) begin
					n_zero_alloc++;
				end else if (int'(r.count) > PAGES) begin
					res.status = ST_NO_ROOM;
					n_refused++;
				end else begin
					run = 0;
					start = 0;
					for (i = 0; i < PAGES && run < int'(r.count); i++) begin
						if (used[i]) begin
							run = 0;
						end else begin
							if (run == 0)
								start = i;
							run++;
						end
					end
					if (run < int'(r.count)) begin
						res.status = ST_NO_ROOM;
						n_refused++;
					end else begin
						for (i = start; i < start + int'(r.count); i++)
							used[i] = 1'b1;
						res.page = PAGE_W'(start);
						n_placed++;
					end
				end
			end else begin
				if (r.first_page == BAD_PAGE_ID) begin
					n_invalid_id++;
				end else if (int'(r.first_page) + int'(r.count) > PAGES) begin
					res.status = ST_RANGE;
					n_out_of_range++;
				end else begin
					for (i = int'(r.first_page); i < int'(r.first_page) + int'(r.count); i++)
						used[i] = 1'b0;
					n_freed++;
				end
			end
			return res;
		endfunction

		function void note_request(req_t r);
			pending_results.push_back(apply_request(r));
		endfunction

		function void check_result(rsp_t got);
			rsp_t exp_res;
			n_checked++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result page %0d status %0d",
						$time, got.page, got.status);
				return;
			end
			exp_res = pending_results.pop_front();
			if (got.page !== exp_res.page || got.status !== exp_res.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch page exp %0d got %0d, status exp %0d got %0d",
						$time, exp_res.page, got.page, exp_res.status, got.status);
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	page_map_scoreboard sb;
	int  cycle_count = 0;
	bit  calm = 1'b0;

	first_fit_page_run_allocator_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// clock and cycle count
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// mostly short gaps, now and then a long one, none while calm
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	// result side: random stall pattern
	initial begin : rsp_stall_gen
		int n;
		rsp_stall <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			n = pick_gap();
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
				rsp_stall <= 1'b0;
			end
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_result(rsp);
	end

	// hold one item until it is accepted
	task automatic send_request(input req_t r);
		int n;
		n = pick_gap();
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (req_stall);
		sb.note_request(r);
	endtask

	task automatic send_op(input op_t op, input int count, input int first);
		req_t r;
		r.operation = op;
		r.count = COUNT_W'(count);
		r.first_page = FIRST_W'(first);
		send_request(r);
	endtask

	// pause the sender until every result is in
	task automatic wait_all_results();
		int n;
		n = 0;
		req_valid <= 1'b0;
		while (sb.pending() != 0 && n < DRAIN_CYCLES) begin
			@(posedge clk);
			n++;
		end
	endtask

	function automatic int pick_alloc_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 16);
		if (r < 85)
			return $urandom_range(17, 128);
		if (r < 95)
			return $urandom_range(129, 600);
		if (r < 97)
			return 0;
		if (r < 98)
			return PAGES;
		return $urandom_range(PAGES + 1, 2047);
	endfunction

	// free a run that starts on a used page if there is one, mostly over used pages
	function automatic req_t pick_used_run();
		req_t r;
		int   p;
		int   k;
		int   len;
		int   lim;
		p = $urandom_range(0, PAGES - 1);
		for (k = 0; k < PAGES && !sb.used[p]; k++)
			p = (p + 1) % PAGES;
		lim = $urandom_range(1, 128);
		len = 0;
		while (p + len < PAGES && len < lim
			&& (sb.used[p + len] || $urandom_range(0, 9) == 0))
			len++;
		if (len == 0)
			len = 1;
		r.operation = OP_FREE;
		r.count = COUNT_W'(len);
		r.first_page = FIRST_W'(p);
		return r;
	endfunction

	function automatic req_t pick_random_item();
		req_t r;
		int   sel;
		int   p;
		sel = $urandom_range(0, 99);
		if (sel < 50) begin
			r.operation = OP_ALLOC;
			r.count = COUNT_W'(pick_alloc_count());
			r.first_page = FIRST_W'($urandom());
		end else if (sel < 85) begin
			r = pick_used_run();
		end else if (sel < 95) begin
			p = $urandom_range(0, PAGES - 1);
			r.operation = OP_FREE;
			r.first_page = FIRST_W'(p);
			r.count = COUNT_W'($urandom_range(0, PAGES - p + 2));
		end else begin
			r.operation = OP_FREE;
			r.count = COUNT_W'($urandom());
			r.first_page = ($urandom_range(0, 1) == 0) ? BAD_PAGE_ID : FIRST_W'($urandom());
		end
		return r;
	endfunction

	// watchdog
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("RESULT: ERROR");
		$finish;
	end

	// main sequence
	initial begin : main_seq
		int i;
		int leftover;
		sb = new();
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items: limits, full map, holes, word edges, bad ranges
		send_op(OP_ALLOC, 0, 0);
		send_op(OP_ALLOC, 2047, 0);
		send_op(OP_ALLOC, PAGES + 1, 0);
		send_op(OP_ALLOC, PAGES, 0);
		send_op(OP_ALLOC, 1, 0);
		send_op(OP_FREE, 2047, 65535);
		send_op(OP_FREE, 0, 65535);
		send_op(OP_FREE, 2, PAGES - 1);
		send_op(OP_FREE, 0, 0);
		send_op(OP_FREE, 1, 512);
		send_op(OP_ALLOC, 2, 0);
		send_op(OP_ALLOC, 1, 0);
		send_op(OP_FREE, PAGES, 0);
		send_op(OP_FREE, 50, 100);
		send_op(OP_ALLOC, 63, 0);
		send_op(OP_ALLOC, 2, 0);
		send_op(OP_ALLOC, 64, 0);
		send_op(OP_FREE, 20, 10);
		send_op(OP_ALLOC, 25, 0);
		send_op(OP_ALLOC, 20, 0);
		send_op(OP_ALLOC, 900, 0);
		send_op(OP_FREE, 0, PAGES);
		send_op(OP_FREE, 2, 65534);
		send_op(OP_FREE, 2047, 0);
		send_op(OP_FREE, PAGES, 0);
		wait_all_results();

		// random items with a calm stretch and one full drain midway
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			calm = (i >= 300 && i < 450);
			if (i == 750)
				wait_all_results();
			if (i % 400 == 399)
				send_op(OP_FREE, PAGES, 0);
			else
				send_request(pick_random_item());
		end
		calm = 1'b0;

		// drain and settle
		wait_all_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		leftover = sb.pending();
		if (leftover != 0)
			$display("%0d expected results never arrived", leftover);

		$display("checked %0d results: %0d runs placed, %0d refused, %0d zero-length",
			sb.n_checked, sb.n_placed, sb.n_refused, sb.n_zero_alloc);
		$display("frees: %0d applied, %0d out of range, %0d invalid id; %0d mismatches",
			sb.n_freed, sb.n_out_of_range, sb.n_invalid_id, sb.mismatches);
		if (sb.mismatches == 0 && leftover == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/ffpa_pkg.sv
hw/rtl/ffpa_dpath.sv
hw/rtl/ffpa_ctrl.sv
hw/rtl/first_fit_page_run_allocator_core.sv
verif/tb.sv
